@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SXD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sxd check failed");

// next-cycle implication, disabled while reset is low
`define SXD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sxd check failed");

// next-cycle implication that also holds through reset
`define SXD_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sxd check failed");

`endif

@@ rtl/core/sxd_pkg.sv @@
// shared constants, types and helper functions for the sprite draw engine
// no dependencies
package sxd_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int WORD_W        = 64;
  localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);
  localparam int COL_AW        = $clog2(SCREEN_WIDTH);

  // item field widths
  localparam int MODE_W   = 2;
  localparam int POS_W    = 8;
  localparam int RIDX_W   = 4;
  localparam int SPRITE_W = 8;

  // coordinate sums fit in nine bits; screen sizes of eight and up need
  // six conditional subtract steps to bring them into range
  localparam int SUM_W      = 9;
  localparam int WRAP_STEPS = 6;
  localparam int WRAP_W     = 16;

  // work queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_CLEAR,
    OP_READ,
    OP_IGNORE
  } op_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t               op;
    logic              first_row;
    logic [ROW_AW-1:0] row;
    logic [WORD_W-1:0] pattern;
  } work_t;

  // reduce a nine-bit coordinate modulo a screen size by restoring subtraction
  function automatic logic [SUM_W-1:0] wrap_mod(input logic [SUM_W-1:0] v,
                                               input int unsigned m);
    logic [WRAP_W-1:0] acc;
    logic [WRAP_W-1:0] step;
    acc = WRAP_W'(v);
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      step = WRAP_W'(m) << k;
      if (acc >= step) begin
        acc = acc - step;
      end
    end
    return acc[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/core/sprite_xor_draw_engine.sv @@
// XOR sprite draw engine on a 64x32 monochrome framebuffer. Each item
// (draw one sprite row, clear screen, read one row) gives exactly one result:
// the collision flag and a 64-bit screen row, bit 0 being column 0. In the
// back end an item passes the registered framebuffer read at the pop, then
// the update and write back in the execute state, which waits while the
// output is stalled; the next item is popped only after that. out_valid is
// registered at execute. The input side keeps taking items into a two-entry
// queue while a result waits at the output. Clearing the screen takes one item
// slot: per-row valid bits blank all rows at once, so there is no clearing
// pass after reset.
// depends on sxd_pkg, sxd_front, sxd_queue, sxd_back
module sprite_xor_draw_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sxd_pkg::MODE_W-1:0]    in_mode,
  input  logic [sxd_pkg::POS_W-1:0]     in_x_pos,
  input  logic [sxd_pkg::POS_W-1:0]     in_y_pos,
  input  logic [sxd_pkg::RIDX_W-1:0]    in_row_index,
  input  logic [sxd_pkg::SPRITE_W-1:0]  in_sprite_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_collision,
  output logic [sxd_pkg::WORD_W-1:0]    out_pixel_row
);

  sxd_pkg::work_t front_item;
  sxd_pkg::work_t q_head;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           q_push;

  // input transfer goes straight into the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify
  sxd_front u_front (
    .mode        (in_mode),
    .x_pos       (in_x_pos),
    .y_pos       (in_y_pos),
    .row_index   (in_row_index),
    .sprite_byte (in_sprite_byte),
    .item        (front_item)
  );

  // decoupling queue
  sxd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // execute
  sxd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_collision (out_collision),
    .out_pixel_row (out_pixel_row)
  );

endmodule

@@ rtl/core/sxd_front.sv @@
// front end: classifies an input item and builds its row address and pattern
// depends on sxd_pkg
module sxd_front (
  input  logic [sxd_pkg::MODE_W-1:0]   mode,
  input  logic [sxd_pkg::POS_W-1:0]    x_pos,
  input  logic [sxd_pkg::POS_W-1:0]    y_pos,
  input  logic [sxd_pkg::RIDX_W-1:0]   row_index,
  input  logic [sxd_pkg::SPRITE_W-1:0] sprite_byte,
  output sxd_pkg::work_t               item
);

  logic [sxd_pkg::SUM_W-1:0]  y_draw;
  logic [sxd_pkg::SUM_W-1:0]  y_read;
  logic [sxd_pkg::WORD_W-1:0] pattern;

  // wrapped target rows for draw and read
  assign y_draw = sxd_pkg::wrap_mod(sxd_pkg::SUM_W'(y_pos) + sxd_pkg::SUM_W'(row_index),
                                    sxd_pkg::SCREEN_HEIGHT);
  assign y_read = sxd_pkg::wrap_mod(sxd_pkg::SUM_W'(y_pos), sxd_pkg::SCREEN_HEIGHT);

  // scatter sprite bits onto wrapped columns, msb at x_pos
  always_comb begin
    logic [sxd_pkg::SUM_W-1:0] col;
    pattern = '0;
    for (int i = 0; i < sxd_pkg::SPRITE_W; i++) begin
      col = sxd_pkg::wrap_mod(sxd_pkg::SUM_W'(x_pos) + sxd_pkg::SUM_W'(i),
                              sxd_pkg::SCREEN_WIDTH);
      if (sprite_byte[sxd_pkg::SPRITE_W-1-i]) begin
        pattern[col[sxd_pkg::COL_AW-1:0]] = 1'b1;
      end
    end
  end

  // classify
  always_comb begin
    item.first_row = (row_index == '0);
    item.pattern   = pattern;
    item.row       = y_draw[sxd_pkg::ROW_AW-1:0];
    unique case (mode)
      sxd_pkg::MODE_DRAW: begin
        item.op = sxd_pkg::OP_DRAW;
      end
      sxd_pkg::MODE_CLEAR: begin
        item.op = sxd_pkg::OP_CLEAR;
      end
      sxd_pkg::MODE_READ: begin
        item.op  = sxd_pkg::OP_READ;
        item.row = y_read[sxd_pkg::ROW_AW-1:0];
      end
      default: begin
        item.op = sxd_pkg::OP_IGNORE;
      end
    endcase
  end

endmodule

@@ rtl/core/sxd_queue.sv @@
// short work queue that decouples the front end from the back end
// depends on sxd_pkg
module sxd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sxd_pkg::work_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output sxd_pkg::work_t head
);

  sxd_pkg::work_t              entry_r [sxd_pkg::Q_DEPTH];
  logic [sxd_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [sxd_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [sxd_pkg::Q_AW:0]      count_r;

  assign full  = (count_r == (sxd_pkg::Q_AW+1)'(sxd_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sxd_pkg::Q_AW'(sxd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sxd_pkg::Q_AW'(sxd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/sxd_back.sv @@
// back end: framebuffer read-modify-write, collision flag and result register
// depends on sxd_pkg
module sxd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  sxd_pkg::work_t              q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_collision,
  output logic [sxd_pkg::WORD_W-1:0]  out_pixel_row
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                      state_r;
  sxd_pkg::work_t              cur_r;
  logic [sxd_pkg::WORD_W-1:0]  fb_mem [sxd_pkg::SCREEN_HEIGHT];
  logic [sxd_pkg::WORD_W-1:0]  rd_data_r;
  logic                        rd_vld_r;
  logic [sxd_pkg::SCREEN_HEIGHT-1:0] row_vld_r;
  logic                        flag_r;
  logic                        out_valid_r;
  logic                        collision_r;
  logic [sxd_pkg::WORD_W-1:0]  pixel_r;

  logic                        out_free;
  logic                        exec;
  logic [sxd_pkg::WORD_W-1:0]  old_row;
  logic [sxd_pkg::WORD_W-1:0]  new_row;
  logic                        hit;
  logic                        flag_nxt;
  logic [sxd_pkg::WORD_W-1:0]  pixel_nxt;

  assign q_pop         = (state_r == ST_IDLE) && !q_empty;
  assign out_free      = !out_valid_r || !out_stall;
  assign exec          = (state_r == ST_EXEC) && out_free;
  assign out_valid     = out_valid_r;
  assign out_collision = collision_r;
  assign out_pixel_row = pixel_r;

  // rows never written since the last clear read as blank
  assign old_row = rd_vld_r ? rd_data_r : '0;
  assign new_row = old_row ^ cur_r.pattern;
  assign hit     = |(old_row & cur_r.pattern);

  // result and flag update
  always_comb begin
    flag_nxt  = flag_r;
    pixel_nxt = '0;
    unique case (cur_r.op)
      sxd_pkg::OP_DRAW: begin
        flag_nxt  = (cur_r.first_row ? 1'b0 : flag_r) | hit;
        pixel_nxt = new_row;
      end
      sxd_pkg::OP_READ: begin
        pixel_nxt = old_row;
      end
      default: begin
        pixel_nxt = '0;
      end
    endcase
  end

  // framebuffer memory: registered read at pop, write at execute
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r <= fb_mem[q_head.row];
    end
    if (exec && (cur_r.op == sxd_pkg::OP_DRAW)) begin
      fb_mem[cur_r.row] <= new_row;
    end
  end

  // sequencer, row valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      // result offered on execute, dropped once transferred
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            cur_r    <= q_head;
            rd_vld_r <= row_vld_r[q_head.row];
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec) begin
            collision_r <= flag_nxt;
            pixel_r     <= pixel_nxt;
            flag_r      <= flag_nxt;
            if (cur_r.op == sxd_pkg::OP_DRAW) begin
              row_vld_r[cur_r.row] <= 1'b1;
            end else if (cur_r.op == sxd_pkg::OP_CLEAR) begin
              row_vld_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sxd_checker.sv @@
// port-level checks for the sprite draw engine, bound to the top level
// depends on sxd_pkg and assert_macros.svh
`include "assert_macros.svh"

module sxd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_collision,
  input logic [sxd_pkg::WORD_W-1:0] out_pixel_row
);

  // a stalled result stays offered and unchanged
  `SXD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel_row) && $stable(out_collision))

  // no lit pixel beyond the screen's right edge
  `SXD_ASSERT_IMP(a_row_width, clk, rst_n, out_valid, (out_pixel_row >> sxd_pkg::SCREEN_WIDTH) == '0)

  // reset empties the output register
  `SXD_ASSERT_RST(a_rst_out, clk, !rst_n, !out_valid)

  // reset empties the work queue, so input is open
  `SXD_ASSERT_RST(a_rst_in, clk, !rst_n, !in_stall)

endmodule

bind sprite_xor_draw_engine sxd_checker u_sxd_checker (.*);

@@ tb/sv/sprite_xor_draw_engine_test.sv @@
// self-checking testbench for the sprite xor draw engine: directed, random and back-to-back items
// depends on sxd_pkg and the sprite_xor_draw_engine rtl
module sprite_xor_draw_engine_test;
  import sxd_pkg::*;

  // mode code that the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic              collision;
    logic [WORD_W-1:0] pixel_row;
  } row_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [POS_W-1:0]    in_x_pos = '0;
  logic [POS_W-1:0]    in_y_pos = '0;
  logic [RIDX_W-1:0]   in_row_index = '0;
  logic [SPRITE_W-1:0] in_sprite_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_collision;
  logic [WORD_W-1:0]   out_pixel_row;

  // screen copy kept alongside the block
  logic [WORD_W-1:0] screen_model [SCREEN_HEIGHT];
  logic              flag_model = 1'b0;
  row_result_t       pending_rows [$];
  row_result_t       head_row;

  bit no_idle = 1'b0;
  int rx_wait = 0;
  int fail_count = 0;
  int n_checked = 0;
  int n_work = 0;
  int n_draw = 0;
  int n_collide = 0;
  int n_clear = 0;
  int n_read = 0;
  int n_ignored = 0;
  int cycle_count = 0;

  sprite_xor_draw_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_row_index   (in_row_index),
    .in_sprite_byte (in_sprite_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_collision  (out_collision),
    .out_pixel_row  (out_pixel_row)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int r = 0; r < SCREEN_HEIGHT; r++) screen_model[r] = '0;
  end

  function void note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endfunction

  // apply one item to the screen copy and return the row it should produce
  function automatic row_result_t apply_to_screen(input logic [MODE_W-1:0] mode,
                                                  input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y,
                                                  input logic [RIDX_W-1:0] ridx,
                                                  input logic [SPRITE_W-1:0] bits);
    row_result_t       res;
    logic [WORD_W-1:0] pattern;
    int unsigned       line;
    res = '0;
    pattern = '0;
    case (mode)
      MODE_DRAW: begin
        line = (y + ridx) % SCREEN_HEIGHT;
        if (ridx == '0) flag_model = 1'b0;
        // msb lands leftmost, columns wrap at the right edge
        for (int b = 0; b < SPRITE_W; b++) begin
          if (bits[SPRITE_W-1-b]) pattern[(x + b) % SCREEN_WIDTH] = 1'b1;
        end
        if ((screen_model[line] & pattern) != '0) flag_model = 1'b1;
        screen_model[line] ^= pattern;
        res.pixel_row = screen_model[line];
      end
      MODE_CLEAR: begin
        for (int r = 0; r < SCREEN_HEIGHT; r++) screen_model[r] = '0;
      end
      MODE_READ: begin
        res.pixel_row = screen_model[y % SCREEN_HEIGHT];
      end
      default: ;
    endcase
    res.collision = flag_model;
    return res;
  endfunction

  // send one item, record its expected row at the transfer
  task automatic issue_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [RIDX_W-1:0] ridx,
                            input logic [SPRITE_W-1:0] bits);
    int          gap;
    row_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_x_pos       <= x;
    in_y_pos       <= y;
    in_row_index   <= ridx;
    in_sprite_byte <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_to_screen(mode, x, y, ridx, bits);
    pending_rows.insert(pending_rows.size(), res);
    case (mode)
      MODE_DRAW: begin
        n_draw++;
        if (res.collision) n_collide++;
      end
      MODE_CLEAR: n_clear++;
      MODE_READ: n_read++;
      default: n_ignored++;
    endcase
    if (mode != MODE_SPARE) n_work++;
    @(negedge clk);
  endtask

  // hold the input side until every pending row has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_rows.size() != 0) @(negedge clk);
  endtask

  // one well-formed sprite: rows 0..h-1 at a random spot
  task automatic random_sprite();
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    int               h;
    x = POS_W'($urandom);
    y = POS_W'($urandom);
    h = $urandom_range(1, 15);
    for (int r = 0; r < h; r++) begin
      issue_item(MODE_DRAW, x, y, RIDX_W'(r), SPRITE_W'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    // empty screen after reset, read row wraps
    issue_item(MODE_READ, 8'd0, 8'd0, 4'd0, 8'd0);
    issue_item(MODE_READ, 8'd255, 8'd255, 4'd15, 8'd255);
    // full byte drawn twice erases it and sets the flag
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF);
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF);
    // flag holds over a blank later row, then row zero clears it
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd1, 8'h00);
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h00);
    // both coordinates at their top, bits spill past the right edge
    issue_item(MODE_DRAW, 8'd255, 8'd255, 4'd15, 8'hFF);
    issue_item(MODE_DRAW, 8'd60, 8'd31, 4'd1, 8'h81);
    issue_item(MODE_DRAW, 8'd63, 8'd0, 4'd0, 8'h80);
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h01);
    issue_item(MODE_READ, 8'd0, 8'd14, 4'd0, 8'd0);
    issue_item(MODE_READ, 8'd0, 8'd46, 4'd0, 8'd0);
    // later row with no row zero before it keeps accumulating
    issue_item(MODE_DRAW, 8'd0, 8'd7, 4'd7, 8'hAA);
    // ignored mode code
    issue_item(MODE_SPARE, 8'd255, 8'd255, 4'd15, 8'hFF);
    issue_item(MODE_SPARE, 8'd0, 8'd0, 4'd0, 8'h00);
    // clear keeps the flag
    issue_item(MODE_CLEAR, 8'd255, 8'd255, 4'd15, 8'hFF);
    issue_item(MODE_READ, 8'd0, 8'd14, 4'd0, 8'd0);
    issue_item(MODE_DRAW, 8'd0, 8'd0, 4'd15, 8'h55);
    issue_item(MODE_READ, 8'd255, 8'd15, 4'd15, 8'hFF);
    issue_item(MODE_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    int pick;
    bit paused;
    start = n_work;
    paused = 1'b0;
    while (n_work - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        random_sprite();
      end else if (pick < 80) begin
        issue_item(MODE_READ, POS_W'($urandom), POS_W'($urandom), RIDX_W'($urandom),
                   SPRITE_W'($urandom));
      end else if (pick < 83) begin
        issue_item(MODE_CLEAR, POS_W'($urandom), POS_W'($urandom), RIDX_W'($urandom),
                   SPRITE_W'($urandom));
      end else if (pick < 88) begin
        issue_item(MODE_SPARE, POS_W'($urandom), POS_W'($urandom), RIDX_W'($urandom),
                   SPRITE_W'($urandom));
      end else begin
        // broken sprite: rows out of order, no row zero
        repeat ($urandom_range(1, 3)) begin
          issue_item(MODE_DRAW, POS_W'($urandom), POS_W'($urandom),
                     RIDX_W'($urandom_range(1, 15)), SPRITE_W'($urandom));
        end
      end
      // one full pause halfway through
      if (!paused && n_work - start >= count / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    wait_for_results();
  endtask

  task automatic test_back_to_back(input int count);
    int start;
    start = n_work;
    no_idle = 1'b1;
    while (n_work - start < count) random_sprite();
    wait_for_results();
    no_idle = 1'b0;
  endtask

  // result side: stall draw per transfer, then check against the oldest pending row
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        note_failure($sformatf("unexpected result collision=%0b row=%h",
                               out_collision, out_pixel_row));
      end else begin
        head_row = pending_rows.pop_front();
        n_checked++;
        if (out_collision !== head_row.collision) begin
          note_failure($sformatf("collision expected %0b got %0b",
                                 head_row.collision, out_collision));
        end
        if (out_pixel_row !== head_row.pixel_row) begin
          note_failure($sformatf("pixel_row expected %h got %h",
                                 head_row.pixel_row, out_pixel_row));
        end
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 4);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d rows pending", cycle_count,
               pending_rows.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_random_traffic(700);
    test_back_to_back(150);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_rows.size() != 0) begin
      note_failure($sformatf("%0d rows never came back", pending_rows.size()));
    end
    $display("covered %0d draw rows (%0d with collision), %0d clears, %0d reads, %0d ignored",
             n_draw, n_collide, n_clear, n_read, n_ignored);
    $display("%0d results checked in %0d cycles, %0d failures", n_checked, cycle_count,
             fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
